>>> hdl/s512_pkg.sv
// Shared types, state encodings and SHA-512 constant tables.
// No dependencies; the design modules import this package.
package s512_pkg;

    localparam int WordW   = 64;
    localparam int BlkWords = 16;
    localparam int Rounds  = 80;

    typedef logic [BlkWords-1:0][WordW-1:0] t_block;

    typedef struct packed {
        logic   fin;
        t_block words;
    } t_job;

    typedef struct packed {
        logic push;
        logic full;
    } t_qctl;

    typedef enum logic {FR_ACCEPT, FR_FLUSH} t_front_state;
    typedef enum logic [1:0] {CR_IDLE, CR_ROUND, CR_UPDATE} t_core_state;

    function automatic logic [63:0] init_hash(input logic [2:0] idx);
        logic [63:0] v;
        case (idx)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            3'd7: v = 64'h5be0cd19137e2179;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] r);
        logic [63:0] v;
        case (r)
            7'd0:  v = 64'h428a2f98d728ae22; 7'd1:  v = 64'h7137449123ef65cd;
            7'd2:  v = 64'hb5c0fbcfec4d3b2f; 7'd3:  v = 64'he9b5dba58189dbbc;
            7'd4:  v = 64'h3956c25bf348b538; 7'd5:  v = 64'h59f111f1b605d019;
            7'd6:  v = 64'h923f82a4af194f9b; 7'd7:  v = 64'hab1c5ed5da6d8118;
            7'd8:  v = 64'hd807aa98a3030242; 7'd9:  v = 64'h12835b0145706fbe;
            7'd10: v = 64'h243185be4ee4b28c; 7'd11: v = 64'h550c7dc3d5ffb4e2;
            7'd12: v = 64'h72be5d74f27b896f; 7'd13: v = 64'h80deb1fe3b1696b1;
            7'd14: v = 64'h9bdc06a725c71235; 7'd15: v = 64'hc19bf174cf692694;
            7'd16: v = 64'he49b69c19ef14ad2; 7'd17: v = 64'hefbe4786384f25e3;
            7'd18: v = 64'h0fc19dc68b8cd5b5; 7'd19: v = 64'h240ca1cc77ac9c65;
            7'd20: v = 64'h2de92c6f592b0275; 7'd21: v = 64'h4a7484aa6ea6e483;
            7'd22: v = 64'h5cb0a9dcbd41fbd4; 7'd23: v = 64'h76f988da831153b5;
            7'd24: v = 64'h983e5152ee66dfab; 7'd25: v = 64'ha831c66d2db43210;
            7'd26: v = 64'hb00327c898fb213f; 7'd27: v = 64'hbf597fc7beef0ee4;
            7'd28: v = 64'hc6e00bf33da88fc2; 7'd29: v = 64'hd5a79147930aa725;
            7'd30: v = 64'h06ca6351e003826f; 7'd31: v = 64'h142929670a0e6e70;
            7'd32: v = 64'h27b70a8546d22ffc; 7'd33: v = 64'h2e1b21385c26c926;
            7'd34: v = 64'h4d2c6dfc5ac42aed; 7'd35: v = 64'h53380d139d95b3df;
            7'd36: v = 64'h650a73548baf63de; 7'd37: v = 64'h766a0abb3c77b2a8;
            7'd38: v = 64'h81c2c92e47edaee6; 7'd39: v = 64'h92722c851482353b;
            7'd40: v = 64'ha2bfe8a14cf10364; 7'd41: v = 64'ha81a664bbc423001;
            7'd42: v = 64'hc24b8b70d0f89791; 7'd43: v = 64'hc76c51a30654be30;
            7'd44: v = 64'hd192e819d6ef5218; 7'd45: v = 64'hd69906245565a910;
            7'd46: v = 64'hf40e35855771202a; 7'd47: v = 64'h106aa07032bbd1b8;
            7'd48: v = 64'h19a4c116b8d2d0c8; 7'd49: v = 64'h1e376c085141ab53;
            7'd50: v = 64'h2748774cdf8eeb99; 7'd51: v = 64'h34b0bcb5e19b48a8;
            7'd52: v = 64'h391c0cb3c5c95a63; 7'd53: v = 64'h4ed8aa4ae3418acb;
            7'd54: v = 64'h5b9cca4f7763e373; 7'd55: v = 64'h682e6ff3d6b2b8a3;
            7'd56: v = 64'h748f82ee5defb2fc; 7'd57: v = 64'h78a5636f43172f60;
            7'd58: v = 64'h84c87814a1f0ab72; 7'd59: v = 64'h8cc702081a6439ec;
            7'd60: v = 64'h90befffa23631e28; 7'd61: v = 64'ha4506cebde82bde9;
            7'd62: v = 64'hbef9a3f7b2c67915; 7'd63: v = 64'hc67178f2e372532b;
            7'd64: v = 64'hca273eceea26619c; 7'd65: v = 64'hd186b8c721c0c207;
            7'd66: v = 64'heada7dd6cde0eb1e; 7'd67: v = 64'hf57d4f7fee6ed178;
            7'd68: v = 64'h06f067aa72176fba; 7'd69: v = 64'h0a637dc5a2c898a6;
            7'd70: v = 64'h113f9804bef90dae; 7'd71: v = 64'h1b710b35131c471b;
            7'd72: v = 64'h28db77f523047d84; 7'd73: v = 64'h32caab7b40c72493;
            7'd74: v = 64'h3c9ebe0a15c9bebc; 7'd75: v = 64'h431d67c49c100d4c;
            7'd76: v = 64'h4cc5d4becb3e42b6; 7'd77: v = 64'h597f299cfc657e2a;
            7'd78: v = 64'h5fcb6fab3ad6faec; 7'd79: v = 64'h6c44198c4a475817;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/s512_front.sv
// Front end: packs message bytes into 128-byte blocks and appends padding.
// Depends on s512_pkg; pushes finished blocks into s512_queue.
module s512_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [63:0]   i_data,
    input  logic [3:0]    i_count,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_push,
    output s512_pkg::t_job o_job
);
    import s512_pkg::*;

    t_front_state r_state, n_state;
    logic [6:0]   r_fill, n_fill;
    logic [63:0]  r_bits, n_bits;
    t_block       r_acc, n_acc;

    logic [3:0]   cnt;
    logic [63:0]  dmask, dm, hi, lo, keep;
    logic [3:0]   wi;
    logic [2:0]   off, fo;
    logic [7:0]   total;
    logic         complete, fire;
    logic [6:0]   f;
    logic [63:0]  bits_new;
    t_block       upd, psrc, pad, zlen;

    assign cnt      = i_count[3] ? 4'd8 : i_count;
    assign dmask    = ~({64{1'b1}} >> {cnt, 3'b000});
    assign dm       = i_data & dmask;
    assign wi       = r_fill[6:3];
    assign off      = r_fill[2:0];
    assign hi       = dm >> {off, 3'b000};
    assign lo       = dm << (7'd64 - {1'b0, off, 3'b000});
    assign keep     = ~({64{1'b1}} >> {off, 3'b000});
    assign total    = {1'b0, r_fill} + {4'b0000, cnt};
    assign complete = total[7];
    assign f        = total[6:0];
    assign fo       = f[2:0];
    assign bits_new = r_bits + {57'b0, cnt, 3'b000};
    assign fire     = i_valid && o_ready;

    // Merge the new bytes into the current block.
    always_comb begin
        upd = r_acc;
        for (int j = 0; j < BlkWords; j++) begin
            if (4'(j) == wi) begin
                upd[j] = (r_acc[j] & keep) | hi;
            end else if (4'(j) == wi + 4'd1 && wi != 4'd15) begin
                upd[j] = lo;
            end
        end
    end

    // Padded image of the block holding f bytes: 0x80 marker, zeros after.
    always_comb begin
        psrc = upd;
        if (complete) begin
            psrc[0] = lo;
        end
        for (int j = 0; j < BlkWords; j++) begin
            if (4'(j) < f[6:3]) begin
                pad[j] = psrc[j];
            end else if (4'(j) == f[6:3]) begin
                pad[j] = (psrc[j] & ~({64{1'b1}} >> {fo, 3'b000}))
                       | (64'h8000000000000000 >> {fo, 3'b000});
            end else begin
                pad[j] = '0;
            end
        end
        zlen     = '0;
        zlen[15] = bits_new;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_ACCEPT: begin
                if (fire && i_last && (complete || f > 7'd111)) begin
                    n_state = FR_FLUSH;
                end
            end
            FR_FLUSH: begin
                if (!i_full) begin
                    n_state = FR_ACCEPT;
                end
            end
            default: n_state = FR_ACCEPT;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        o_job   = '0;
        n_fill  = r_fill;
        n_bits  = r_bits;
        n_acc   = r_acc;
        case (r_state)
            FR_ACCEPT: begin
                o_ready = !i_full;
                if (fire) begin
                    n_fill = f;
                    n_bits = bits_new;
                    if (complete) begin
                        o_push    = 1'b1;
                        o_job.fin = 1'b0;
                        o_job.words = upd;
                        n_acc     = psrc;
                    end else begin
                        n_acc = upd;
                    end
                    if (i_last) begin
                        n_fill = '0;
                        n_bits = '0;
                        if (complete) begin
                            // Data closed a block: padding goes in a second block.
                            n_acc     = pad;
                            n_acc[15] = bits_new;
                        end else if (f <= 7'd111) begin
                            o_push      = 1'b1;
                            o_job.fin   = 1'b1;
                            o_job.words = pad;
                            o_job.words[15] = bits_new;
                        end else begin
                            o_push      = 1'b1;
                            o_job.fin   = 1'b0;
                            o_job.words = pad;
                            n_acc       = zlen;
                        end
                    end
                end
            end
            FR_FLUSH: begin
                o_push      = !i_full;
                o_job.fin   = 1'b1;
                o_job.words = r_acc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_ACCEPT;
            r_fill  <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
        end
        r_acc <= n_acc;
    end

endmodule

>>> hdl/s512_queue.sv
// Two-entry block queue between the packer and the compression engine.
// Depends on s512_pkg for the job type.
module s512_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  s512_pkg::t_qctl i_ctl,
    input  s512_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output s512_pkg::t_job o_job
);
    import s512_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign wr      = i_ctl.push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

>>> hdl/s512_core.sv
// Back end: 80-round SHA-512 compression and digest word output register.
// Depends on s512_pkg; takes blocks from s512_queue.
module s512_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  s512_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [63:0]    o_word,
    output logic [2:0]     o_index,
    output logic           o_last
);
    import s512_pkg::*;

    t_core_state r_state, n_state;
    logic [6:0]  r_rnd;
    logic        r_fin;
    t_block      r_w;
    logic [7:0][63:0] r_h, r_v, r_dig, sum;
    logic        r_obusy;
    logic [2:0]  r_oidx;
    logic        load, do_round, do_upd, oacc;
    logic [63:0] t1, t2, wnew, s0, s1, bs0, bs1, ch, maj;

    function automatic logic [63:0] rotr(input logic [63:0] x, input logic [5:0] n);
        return (x >> n) | (x << (7'd64 - {1'b0, n}));
    endfunction

    assign s0   = rotr(r_w[1], 6'd1) ^ rotr(r_w[1], 6'd8) ^ (r_w[1] >> 7);
    assign s1   = rotr(r_w[14], 6'd19) ^ rotr(r_w[14], 6'd61) ^ (r_w[14] >> 6);
    assign wnew = s1 + r_w[9] + s0 + r_w[0];
    assign bs1  = rotr(r_v[4], 6'd14) ^ rotr(r_v[4], 6'd18) ^ rotr(r_v[4], 6'd41);
    assign bs0  = rotr(r_v[0], 6'd28) ^ rotr(r_v[0], 6'd34) ^ rotr(r_v[0], 6'd39);
    assign ch   = r_v[6] ^ (r_v[4] & (r_v[5] ^ r_v[6]));
    assign maj  = (r_v[0] & r_v[1]) | (r_v[2] & (r_v[0] | r_v[1]));
    assign t1   = r_v[7] + bs1 + ch + round_k(r_rnd) + r_w[0];
    assign t2   = bs0 + maj;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sum[i] = r_h[i] + r_v[i];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            CR_IDLE:   if (i_valid) n_state = CR_ROUND;
            CR_ROUND:  if (r_rnd == 7'(Rounds - 1)) n_state = CR_UPDATE;
            CR_UPDATE: if (!(r_fin && r_obusy)) n_state = CR_IDLE;
            default:   n_state = CR_IDLE;
        endcase
    end

    always_comb begin
        load     = 1'b0;
        do_round = 1'b0;
        do_upd   = 1'b0;
        case (r_state)
            CR_IDLE:   load     = i_valid;
            CR_ROUND:  do_round = 1'b1;
            CR_UPDATE: do_upd   = !(r_fin && r_obusy);
            default: ;
        endcase
    end

    assign o_pop   = load;
    assign o_valid = r_obusy;
    assign o_word  = r_dig[0];
    assign o_index = r_oidx;
    assign o_last  = r_oidx == 3'd7;
    assign oacc    = r_obusy && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CR_IDLE;
            r_rnd   <= '0;
            r_obusy <= 1'b0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= init_hash(3'(i));
            end
        end else begin
            r_state <= n_state;
            if (load) r_rnd <= '0;
            else if (do_round) r_rnd <= r_rnd + 7'd1;
            if (oacc) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) r_obusy <= 1'b0;
            end
            if (do_upd) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_fin ? init_hash(3'(i)) : sum[i];
                end
                if (r_fin) begin
                    r_obusy <= 1'b1;
                    r_oidx  <= '0;
                end
            end
        end
        if (load) begin
            r_w   <= i_job.words;
            r_fin <= i_job.fin;
            r_v   <= r_h;
        end
        if (do_round) begin
            for (int j = 0; j < BlkWords - 1; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= wnew;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (oacc) begin
            for (int i = 0; i < 7; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
        if (do_upd && r_fin) begin
            r_dig <= sum;
        end
    end

endmodule

>>> hdl/sha512_message_hasher_top.sv
// Top level of the SHA-512 message hasher: packer, block queue, compression engine.
// Depends on s512_pkg, s512_front, s512_queue and s512_core.
//
// Usage:
//   The slave channel takes the message one big-endian 64-bit word per request;
//   tdata[67:64] is the count of valid bytes taken from the top of the word
//   (values above 8 count as 8), and tlast marks the final word of a message.
//   After the final word, the master channel gives eight requests: digest
//   words 0 to 7 (most significant first), index in tdata[66:64], tlast on
//   word 7. The block then starts a new message from the initial hash.
// Throughput and flow:
//   The packer takes one word per cycle while the two-entry block queue has
//   room and no padding block waits to be flushed. The compression engine
//   handles each 128-byte block in steps: one load, 80 rounds, one chaining
//   add. The first digest word appears once the last block of the message,
//   which may be an extra padding block, has been compressed.
// Reset and stalls:
//   Synchronous active-low reset empties the queue, drops any partial block
//   and restores the initial hash. While the receiver stalls, the digest word
//   holds; the engine keeps hashing queued blocks but holds a second digest
//   until the first one has drained.
module sha512_message_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // [63:0] data_word, [67:64] byte_count, zero fill
    input  logic        s_axis_tlast,  // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // [63:0] digest_word, [66:64] word_index, zero fill
    output logic        m_axis_tlast   // last_word
);
    import s512_pkg::*;

    t_job        push_job, pop_job;
    t_qctl       qctl;
    logic        push, q_full, q_valid, pop;
    logic [63:0] dword;
    logic [2:0]  didx;

    assign qctl.push = push;
    assign qctl.full = q_full;

    s512_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata[63:0]),
        .i_count (s_axis_tdata[67:64]),
        .i_last  (s_axis_tlast),
        .i_full  (qctl.full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Hold blocks here so packing and compression stall independently.
    s512_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (pop_job)
    );

    s512_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (pop_job),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_word  (dword),
        .o_index (didx),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, didx, dword};

endmodule

>>> hdl/s512_checker.sv
// Port-level checks for the SHA-512 hasher, bound to the top level.
// Depends only on the top-level ports.
module s512_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest word changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("digest valid after reset");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[66:64] == 3'd7)))
        else $error("tlast not on word seven");

    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tdata[66:64] == $past(m_axis_tdata[66:64]) + 3'd1)
        else $error("digest words not contiguous");

endmodule

bind sha512_message_hasher_top s512_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> verif/sha512_digest_checker.sv
// Checker for the SHA-512 message hasher: predicts digests from accepted requests
// and compares each digest request field by field. Depends on nothing but the ports.
`timescale 1ns / 100ps

module sha512_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [71:0] i_out_data,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_digests_seen
);

    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_req;

    logic [63:0] chain_h [8];
    logic [63:0] blk [16];
    int unsigned fill_bytes;
    logic [63:0] msg_bits;
    t_digest_req digest_q[$];
    int mismatches;

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] start_hash(input int i);
        logic [63:0] t [8];
        t = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
              64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
              64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
        return t[i];
    endfunction

    function automatic logic [63:0] kconst(input int r);
        logic [63:0] k [80];
        k = '{
            64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
            64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
            64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
            64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
            64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
            64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
            64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
            64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
            64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
            64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
            64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
            64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
            64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
            64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
            64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
            64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
            64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
            64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
            64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
            64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
        return k[r];
    endfunction

    task automatic compress();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 80; i++) begin
            s0 = ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7);
            s1 = ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = chain_h[i];
        for (int r = 0; r < 80; r++) begin
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
                 + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + kconst(r) + w[r];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
                 + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_h[i] += v[i];
    endtask

    // place a byte big-endian; clear the rest of a word on its first byte
    task automatic place_byte(input logic [7:0] b);
        int unsigned wi, off;
        wi = fill_bytes >> 3;
        off = fill_bytes & 7;
        if (off == 0) blk[wi] = 64'(b) << 56;
        else blk[wi] |= 64'(b) << (56 - 8 * off);
        fill_bytes++;
    endtask

    task automatic absorb_request(input logic [71:0] d, input logic last);
        int unsigned n;
        t_digest_req e;
        n = d[67:64];
        if (n > 8) n = 8;
        for (int i = 0; i < n; i++) begin
            place_byte(d[63 - 8 * i -: 8]);
            if (fill_bytes == 128) begin
                compress();
                msg_bits += 1024;
                fill_bytes = 0;
            end
        end
        if (!last) return;
        msg_bits += 64'(fill_bytes) * 8;
        place_byte(8'h80);
        if (fill_bytes > 112) begin
            while (fill_bytes < 128) place_byte(8'h00);
            compress();
            fill_bytes = 0;
        end
        while (fill_bytes < 120) place_byte(8'h00);
        blk[15] = msg_bits;
        compress();
        for (int i = 0; i < 8; i++) begin
            e.word = chain_h[i];
            e.index = 3'(i);
            e.last = (i == 7);
            digest_q.push_back(e);
            chain_h[i] = start_hash(i);
        end
        fill_bytes = 0;
        msg_bits = '0;
    endtask

    initial begin
        for (int i = 0; i < 8; i++) chain_h[i] = start_hash(i);
        for (int i = 0; i < 16; i++) blk[i] = '0;
        fill_bytes = 0;
        msg_bits = '0;
        mismatches = 0;
        o_digests_seen = 0;
    end

    assign o_fail_count = mismatches;
    assign o_pending = digest_q.size();

    always @(posedge i_clk) begin
        t_digest_req e;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) absorb_request(i_in_data, i_in_last);
            if (i_out_valid && i_out_ready) begin
                o_digests_seen++;
                if (digest_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest request data=%h last=%b",
                                 i_out_data, i_out_last);
                end else begin
                    e = digest_q.pop_front();
                    if (i_out_data[63:0] !== e.word || i_out_data[66:64] !== e.index ||
                        i_out_data[71:67] !== 5'd0 || i_out_last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp word=%h idx=%0d last=%b, got %h idx=%0d last=%b",
                                     e.word, e.index, e.last, i_out_data[63:0],
                                     i_out_data[66:64], i_out_last);
                    end
                end
            end
        end
    end

endmodule

>>> verif/testbench.sv
// Top of the SHA-512 hasher testbench: clock, reset, message stimulus and verdict.
// Depends on sha512_digest_checker and sha512_message_hasher_top.
`timescale 1ns / 100ps

module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;  // [63:0] data_word, [67:64] byte_count
    logic        s_axis_tlast = 1'b0;  // last_item
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;  // [63:0] digest_word, [66:64] word_index
    logic        m_axis_tlast;  // last_word

    int fail_count, pending, digests_seen;
    int send_idle_pct, recv_idle_pct;
    int sent_requests, messages;

    always #5 i_clk = ~i_clk;

    sha512_message_hasher_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    sha512_digest_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_last(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending), .o_digests_seen(digests_seen)
    );

    // receiver: draw ready at random at the falling edge by the current idle rate
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // drive one request, hold it until accepted; random gaps before it
    task automatic send_word(input logic [63:0] d, input logic [3:0] n, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, n, d};
        s_axis_tlast <= l;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent_requests++;
        if (l) messages++;
    endtask

    // full words, then a final word of tail bytes (count may exceed 8)
    task automatic send_message(input int full_words, input logic [3:0] tail);
        for (int i = 0; i < full_words; i++)
            send_word({$urandom, $urandom}, ($urandom_range(9) == 0) ?
                      4'($urandom_range(15, 8)) : 4'd8, 1'b0);
        send_word({$urandom, $urandom}, tail, 1'b1);
    endtask

    initial begin
        send_idle_pct = 14;
        recv_idle_pct = 87;
        sent_requests = 0;
        messages = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty message, all-ones and all-zero words, padding edges
        send_word(64'h0, 4'd0, 1'b1);
        send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
        send_word(64'h0, 4'd15, 1'b1);
        send_word(64'h6162_6300_0000_0000, 4'd3, 1'b1);
        send_message(13, 4'd7);   // 111 bytes: padding fits in one block
        send_message(13, 4'd8);   // 112 bytes: padding needs an extra block
        send_message(15, 4'd8);   // exactly one block of message
        // short word that is not last: later words continue mid-word
        send_word(64'hdead_beef_0123_4567, 4'd5, 1'b0);
        send_word(64'h0, 4'd0, 1'b0);
        send_word(64'h8000_0000_0000_0001, 4'd9, 1'b1);

        // random messages across three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 87 : 0;
            recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 14 : 0;
            repeat (12) begin
                if ($urandom_range(3) == 0) begin
                    // byte-granular message from mixed short words
                    repeat ($urandom_range(6)) send_word({$urandom, $urandom},
                                                         4'($urandom_range(8)), 1'b0);
                    send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b1);
                end else begin
                    send_message($urandom_range(($urandom_range(4) == 0) ? 20 : 6),
                                 4'($urandom_range(15)));
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        fork
            while (pending != 0) @(posedge i_clk);
            begin
                #2_000_000;
                $display("timeout waiting for digests");
                $display("Some tests failed");
                $finish;
            end
        join_any
        disable fork;
        repeat (200) @(posedge i_clk);
        $display("sent %0d word requests in %0d messages, checked %0d digest words",
                 sent_requests, messages, digests_seen);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // overall guard on run length
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
